@@ design/edist_pkg.sv @@
// Shared widths, limits and sequencer states of the Euclidean distance engine.
package edist_pkg;

  localparam int SUM_WIDTH  = 42;
  localparam int ROOT_WIDTH = 21;

  localparam logic [SUM_WIDTH-1:0]  SUM_MAX    = '1;
  localparam logic [ROOT_WIDTH-1:0] DIFF_LIMIT = '1;
  localparam logic [SUM_WIDTH-1:0]  ROOT_BIT0  = SUM_WIDTH'(1) << (SUM_WIDTH - 2);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_ACCUM,
    ST_ROOT,
    ST_DELIVER
  } state_t;

endpackage

@@ design/edist_if.sv @@
// Valid/ready channels for component pairs and distance results.
interface edist_pair_if #(
  parameter int ELEM_WIDTH = 16
);
  logic                         valid;
  logic                         ready;
  logic signed [ELEM_WIDTH-1:0] a_elem;
  logic signed [ELEM_WIDTH-1:0] b_elem;
  logic                         last;

  modport source (output valid, a_elem, b_elem, last, input ready);
  modport sink   (input valid, a_elem, b_elem, last, output ready);
endinterface

interface edist_result_if;
  logic                                  valid;
  logic                                  ready;
  logic [edist_pkg::ROOT_WIDTH-1:0]      distance;
  logic                                  saturated;

  modport source (output valid, distance, saturated, input ready);
  modport sink   (input valid, distance, saturated, output ready);
endinterface

@@ design/euclidean_distance_engine.sv @@
// Euclidean distance engine: squared-difference accumulator with an iterative square root.
//
//   channel | dir | payload                       | word
//   --------+-----+-------------------------------+------------------------------------
//   pair    | in  | a_elem, b_elem (Q8.8), last   | one component pair
//   result  | out | distance (Q13.8), saturated   | one distance, on a pair with last
//
// A pair without last passes through capture, square and accumulate before the next is taken.
// A pair with last passes through capture, square and accumulate, the 21 digit steps of
// the shared compare/subtract unit of the root, and the load of the output register.
// The output register holds a result while the sink stalls; the next vector's pairs are
// taken meanwhile, and only the following result waits for the register to drain.
// rst is synchronous and clears the sequencer, the sum, the saturation flag and the output valid.
module euclidean_distance_engine #(
  parameter int ELEM_WIDTH = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  edist_pair_if.sink            pair,
  edist_result_if.source        result
);

  localparam int DW = ELEM_WIDTH + 1;
  localparam int CW = (DW > edist_pkg::ROOT_WIDTH + 1) ? DW : edist_pkg::ROOT_WIDTH + 1;
  localparam logic [CW-1:0] LIMIT = CW'(edist_pkg::DIFF_LIMIT);

  edist_pkg::state_t state, state_next;

  logic signed [DW-1:0]               diff;
  logic                               last_q;
  logic [edist_pkg::SUM_WIDTH-1:0]    square;
  logic                               big;
  logic [edist_pkg::SUM_WIDTH-1:0]    sum_of_squares;
  logic                               overflow_seen;
  logic [edist_pkg::SUM_WIDTH-1:0]    root_op;
  logic [edist_pkg::SUM_WIDTH-1:0]    root_res;
  logic [edist_pkg::SUM_WIDTH-1:0]    root_bit;
  logic                               root_sat;
  logic                               out_valid;
  logic [edist_pkg::ROOT_WIDTH-1:0]   out_distance;
  logic                               out_saturated;

  logic                               accept;
  logic                               load_out;
  logic [DW-1:0]                      mag;
  logic [CW-1:0]                      mag_ext;
  logic [edist_pkg::ROOT_WIDTH-1:0]   mul_op;
  logic [edist_pkg::SUM_WIDTH-1:0]    product;
  logic [edist_pkg::SUM_WIDTH:0]      sum_wide;
  logic [edist_pkg::SUM_WIDTH-1:0]    sum_new;
  logic                               ovf_new;
  logic [edist_pkg::SUM_WIDTH:0]      trial;
  logic                               take;

  assign accept = pair.valid && pair.ready;

  // squaring path
  assign mag     = diff[DW-1] ? DW'(-diff) : DW'(diff);
  assign mag_ext = CW'(mag);
  assign mul_op  = mag_ext[edist_pkg::ROOT_WIDTH-1:0];
  assign product = edist_pkg::SUM_WIDTH'(mul_op) * edist_pkg::SUM_WIDTH'(mul_op);

  // saturating accumulate
  assign sum_wide = {1'b0, sum_of_squares} + {1'b0, square};
  assign ovf_new  = big || sum_wide[edist_pkg::SUM_WIDTH];
  assign sum_new  = ovf_new ? edist_pkg::SUM_MAX : sum_wide[edist_pkg::SUM_WIDTH-1:0];

  // one digit step of the root
  assign trial = {1'b0, root_res} + {1'b0, root_bit};
  assign take  = {1'b0, root_op} >= trial;

  always_comb begin
    state_next = state;
    case (state)
      edist_pkg::ST_IDLE:    if (accept) state_next = edist_pkg::ST_SQUARE;
      edist_pkg::ST_SQUARE:  state_next = edist_pkg::ST_ACCUM;
      edist_pkg::ST_ACCUM:   state_next = last_q ? edist_pkg::ST_ROOT : edist_pkg::ST_IDLE;
      edist_pkg::ST_ROOT:    if (root_bit[0]) state_next = edist_pkg::ST_DELIVER;
      edist_pkg::ST_DELIVER: if (!out_valid || result.ready) state_next = edist_pkg::ST_IDLE;
      default:               state_next = edist_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    pair.ready = 1'b0;
    load_out   = 1'b0;
    case (state)
      edist_pkg::ST_IDLE:    pair.ready = 1'b1;
      edist_pkg::ST_DELIVER: load_out   = !out_valid || result.ready;
      default: begin
        pair.ready = 1'b0;
        load_out   = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= edist_pkg::ST_IDLE;
      sum_of_squares <= '0;
      overflow_seen  <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      state <= state_next;
      if (state == edist_pkg::ST_ACCUM) begin
        if (last_q) begin
          sum_of_squares <= '0;
          overflow_seen  <= 1'b0;
        end else begin
          sum_of_squares <= sum_new;
          overflow_seen  <= overflow_seen || ovf_new;
        end
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      diff   <= DW'($signed(pair.a_elem)) - DW'($signed(pair.b_elem));
      last_q <= pair.last;
    end
    if (state == edist_pkg::ST_SQUARE) begin
      square <= product;
      big    <= mag_ext > LIMIT;
    end
    if (state == edist_pkg::ST_ACCUM) begin
      // start the root on the finished sum
      root_op  <= sum_new;
      root_res <= '0;
      root_bit <= edist_pkg::ROOT_BIT0;
      root_sat <= overflow_seen || ovf_new;
    end else if (state == edist_pkg::ST_ROOT) begin
      if (take) begin
        root_op  <= root_op - trial[edist_pkg::SUM_WIDTH-1:0];
        root_res <= (root_res >> 1) + root_bit;
      end else begin
        root_res <= root_res >> 1;
      end
      root_bit <= root_bit >> 2;
    end
    if (load_out) begin
      out_distance  <= root_res[edist_pkg::ROOT_WIDTH-1:0];
      out_saturated <= root_sat;
    end
  end

  assign result.valid     = out_valid;
  assign result.distance  = out_distance;
  assign result.saturated = out_saturated;

endmodule

@@ design/edist_checker.sv @@
// Port-level checks for the Euclidean distance engine, bound to the top level.
module edist_port_checks (
  input logic                                clk,
  input logic                                rst,
  input logic                                in_valid,
  input logic                                in_ready,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic [edist_pkg::ROOT_WIDTH-1:0]    out_distance,
  input logic                                out_saturated
);

  // hold a stalled result word
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_distance) && $stable(out_saturated))
    else $error("result word changed or dropped while stalled");

  // busy after taking a pair
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("pair taken while the previous one is still in work");

  // a new result word is loaded only from the delivery step, with the input side closed
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result loaded while the input side was open");

  // no result word rises while a taken pair is in its square and accumulate steps
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !$rose(out_valid) ##1 !$rose(out_valid))
    else $error("result appeared too soon after a pair");

endmodule

bind euclidean_distance_engine edist_port_checks u_edist_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (pair.valid),
  .in_ready      (pair.ready),
  .out_valid     (result.valid),
  .out_ready     (result.ready),
  .out_distance  (result.distance),
  .out_saturated (result.saturated)
);
